### design/cfps_pkg.sv
package cfps_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int DEF_TABLE_ENTRIES   = 64;
  localparam int DEF_STORE_ADDR_BITS = 18;
  localparam int MONITOR_SLOTS       = 8;

  // Monitored count and table index counters hold 0 .. 64.
  localparam int CNT_W = 7;

  // Operation codes of an input item.
  localparam logic [1:0] OP_REQ  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_CONF = 2'd2;

  // Job kinds handed from the front to the back.
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_CONF = 2'd2;

  // Request commands, frame bits 63:62.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_TABLE = 2'd3;

  localparam logic [7:0]  UNLOCK_FIRST  = 8'h11;
  localparam logic [7:0]  UNLOCK_SECOND = 8'hFF;
  localparam logic [7:0]  UNLOCK_THIRD  = 8'hEE;
  localparam logic [55:0] COUNT_SIG     = 56'hFFFEFDFCFBFA00;
  localparam logic [7:0]  FRAME_HDR     = 8'h70;
  localparam logic [3:0]  MAX_BURST     = 4'd14;
  localparam logic [3:0]  RESP_CHANNEL  = 4'd8;

  // Configuration register indexes and reset values.
  localparam int          CFG_IDX_W    = 1;
  localparam logic [0:0]  CFG_PERIOD   = 1'b0;
  localparam logic [0:0]  CFG_WINDOW   = 1'b1;
  localparam int          PERIOD_W     = 16;
  localparam int          WINDOW_W     = 18;
  localparam logic [15:0] PERIOD_RESET = 16'd10;
  localparam logic [17:0] WINDOW_RESET = 18'd188415;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] frame;
    logic [31:0] time_ms;
    logic [3:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [63:0] payload;
    logic        last;
  } out_item_t;

  // Classified job in the queue between front and back.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] frame;
    logic [31:0] time_ms;
    logic [3:0]  slot;
    logic        is_first;
    logic        is_second;
    logic        is_third;
    logic        is_count;
  } job_t;

endpackage

### design/cfps_front.sv
module cfps_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  cfps_pkg::in_item_t in_data,
  input  logic               init_done,
  input  logic               q_full,
  output logic               push,
  output cfps_pkg::job_t     job
);

  logic all_first;
  logic all_second;
  logic all_third;
  logic keep;

  // Unlock patterns need every byte of the frame equal.
  always_comb begin
    all_first  = 1'b1;
    all_second = 1'b1;
    all_third  = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (in_data.frame[k*8 +: 8] != cfps_pkg::UNLOCK_FIRST)  all_first  = 1'b0;
      if (in_data.frame[k*8 +: 8] != cfps_pkg::UNLOCK_SECOND) all_second = 1'b0;
      if (in_data.frame[k*8 +: 8] != cfps_pkg::UNLOCK_THIRD)  all_third  = 1'b0;
    end
  end

  // Unknown operations and slot codes are taken and dropped here.
  always_comb begin
    keep          = 1'b0;
    job.kind      = cfps_pkg::KIND_REQ;
    job.frame     = in_data.frame;
    job.time_ms   = in_data.time_ms;
    job.slot      = in_data.slot;
    job.is_first  = all_first;
    job.is_second = all_second;
    job.is_third  = all_third;
    job.is_count  = (in_data.frame[63:8] == cfps_pkg::COUNT_SIG);
    case (in_data.operation)
      cfps_pkg::OP_REQ: begin
        keep     = 1'b1;
        job.kind = cfps_pkg::KIND_REQ;
      end
      cfps_pkg::OP_TICK: begin
        keep     = 1'b1;
        job.kind = cfps_pkg::KIND_TICK;
      end
      cfps_pkg::OP_CONF: begin
        keep     = (in_data.slot <= cfps_pkg::RESP_CHANNEL);
        job.kind = cfps_pkg::KIND_CONF;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = init_done && !q_full;
  assign push     = in_valid && in_ready && keep;

endmodule

### design/cfps_queue.sv
module cfps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cfps_pkg::job_t push_job,
  input  logic           pop,
  output cfps_pkg::job_t head,
  output logic           full,
  output logic           empty
);

  cfps_pkg::job_t slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  assign head  = slots_r[rd_ptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule

### design/cfps_back.sv
module cfps_back #(
  parameter int TABLE_ENTRIES   = cfps_pkg::DEF_TABLE_ENTRIES,
  parameter int STORE_ADDR_BITS = cfps_pkg::DEF_STORE_ADDR_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cfps_pkg::job_t                     job,
  input  logic                               q_empty,
  output logic                               pop,
  output logic                               init_done,
  input  logic [cfps_pkg::PERIOD_W-1:0]      sample_period,
  input  logic [cfps_pkg::WINDOW_W-1:0]      window_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cfps_pkg::out_item_t                out_data
);

  localparam int TIW         = $clog2(TABLE_ENTRIES);
  localparam int STORE_DEPTH = 1 << STORE_ADDR_BITS;
  localparam int CW          = cfps_pkg::CNT_W;
  localparam int NS          = cfps_pkg::MONITOR_SLOTS;
  localparam logic [CW-1:0] TE_CNT = CW'(TABLE_ENTRIES);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_WR    = 5'd3;
  localparam logic [4:0] S_TBL2  = 5'd4;
  localparam logic [4:0] S_WORD  = 5'd5;
  localparam logic [4:0] S_DIV   = 5'd6;
  localparam logic [4:0] S_TDEC  = 5'd7;
  localparam logic [4:0] S_RESP  = 5'd8;
  localparam logic [4:0] S_SAMPA = 5'd9;
  localparam logic [4:0] S_SAMPB = 5'd10;
  localparam logic [4:0] S_HDRA  = 5'd11;
  localparam logic [4:0] S_HDRE  = 5'd12;
  localparam logic [4:0] S_DATA  = 5'd13;
  localparam logic [4:0] S_DATB  = 5'd14;
  localparam logic [4:0] S_DATC  = 5'd15;
  localparam logic [4:0] S_DATE  = 5'd16;

  logic [4:0]                 st_r, st_nxt;
  cfps_pkg::job_t             job_r, job_nxt;
  logic [2:0]                 k_r, k_nxt;
  logic [23:0]                base_r, base_nxt;
  logic [31:0]                word_r, word_nxt;
  logic                       samp_r, samp_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [15:0]                rem_r, rem_nxt;
  logic [31:0]                tsh_r, tsh_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic                       due_r, due_nxt;
  logic                       burst_r, burst_nxt;
  logic [3:0]                 c_r, c_nxt;
  logic [2:0]                 slot_r, slot_nxt;
  logic [31:0]                hi_r, hi_nxt;
  logic [1:0]                 unlock_r, unlock_nxt;
  logic [CW-1:0]              mc_r, mc_nxt;
  logic [CW-1:0]              si_r, si_nxt;
  logic [NS-1:0]              busy_r, busy_nxt;
  logic                       rbusy_r, rbusy_nxt;
  logic                       rpend_r, rpend_nxt;
  logic [63:0]                rframe_r, rframe_nxt;
  logic [STORE_ADDR_BITS-1:0] clr_r, clr_nxt;
  logic                       out_valid_r;
  cfps_pkg::out_item_t        out_data_r, out_data_nxt;
  logic                       out_load;

  logic [7:0]                 store_mem [STORE_DEPTH];
  logic [7:0]                 st_rd_r;
  logic                       st_we;
  logic [STORE_ADDR_BITS-1:0] st_waddr, st_raddr;
  logic [7:0]                 st_wdata;

  logic [23:0]          am_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] am_vld_r;
  logic [23:0]          am_rd_r;
  logic                 am_rv_r;
  logic                 am_we;
  logic [TIW-1:0]       am_waddr, am_raddr;
  logic [23:0]          am_wdata;

  logic [31:0]          sm_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] sm_vld_r;
  logic [31:0]          sm_rd_r;
  logic                 sm_rv_r;
  logic                 sm_we;
  logic [TIW-1:0]       sm_waddr, sm_raddr;
  logic [31:0]          sm_wdata;

  logic [15:0] per;
  logic [16:0] trial;
  logic [23:0] off;
  logic [5:0]  size;
  logic        wr_ok;
  logic        samp_ok;
  logic [23:0] am_val;
  logic [31:0] sm_val;
  logic [23:0] byte_addr;
  logic [CW-1:0] diff;
  logic [CW-1:0] si_inc;
  logic [31:0] word_fill;
  logic        due_now;
  logic        burst_now;
  logic        out_ok;

  assign per       = (sample_period == '0) ? 16'd1 : sample_period;
  assign trial     = {rem_r, tsh_r[31]};
  assign off       = job_r.frame[55:32];
  assign size      = job_r.frame[61:56];
  assign wr_ok     = (size >= 6'd1) && (size <= 6'd4) &&
                     (({1'b0, off} + {19'd0, size}) <= {7'd0, window_last});
  assign am_val    = am_rv_r ? am_rd_r : 24'd0;
  assign sm_val    = sm_rv_r ? sm_rd_r : 32'd0;
  assign samp_ok   = (({1'b0, am_val} + 25'd4) <= {7'd0, window_last});
  assign byte_addr = base_r + {21'd0, k_r};
  assign diff      = mc_r - si_r;
  assign si_inc    = si_r + 7'd1;
  assign word_fill = {st_rd_r, word_r[31:8]};
  assign due_now   = (rem_r == 16'd0);
  assign burst_now = due_now ? (mc_r != '0) : ((si_r < mc_r) && (busy_r == '0));
  assign out_ok    = !out_valid_r || out_ready;

  always_comb begin
    st_nxt       = st_r;
    job_nxt      = job_r;
    k_nxt        = k_r;
    base_nxt     = base_r;
    word_nxt     = word_r;
    samp_nxt     = samp_r;
    idx_nxt      = idx_r;
    rem_nxt      = rem_r;
    tsh_nxt      = tsh_r;
    cnt_nxt      = cnt_r;
    due_nxt      = due_r;
    burst_nxt    = burst_r;
    c_nxt        = c_r;
    slot_nxt     = slot_r;
    hi_nxt       = hi_r;
    unlock_nxt   = unlock_r;
    mc_nxt       = mc_r;
    si_nxt       = si_r;
    busy_nxt     = busy_r;
    rbusy_nxt    = rbusy_r;
    rpend_nxt    = rpend_r;
    rframe_nxt   = rframe_r;
    clr_nxt      = clr_r;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    pop          = 1'b0;
    st_we        = 1'b0;
    st_waddr     = byte_addr[STORE_ADDR_BITS-1:0];
    st_wdata     = job_r.frame[k_r[1:0]*8 +: 8];
    st_raddr     = byte_addr[STORE_ADDR_BITS-1:0];
    am_we        = 1'b0;
    am_waddr     = job_r.frame[56 +: TIW];
    am_wdata     = off;
    am_raddr     = idx_r[TIW-1:0];
    sm_we        = 1'b0;
    sm_waddr     = idx_r[TIW-1:0];
    sm_wdata     = word_fill;
    sm_raddr     = si_r[TIW-1:0];

    case (st_r)
      S_INIT: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = 8'd0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == '1) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          job_nxt = job;
          st_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt = S_IDLE;
        case (job_r.kind)
          cfps_pkg::KIND_REQ: begin
            if (unlock_r == 2'd0) begin
              unlock_nxt = job_r.is_first ? 2'd1 : 2'd0;
            end else if (unlock_r == 2'd1) begin
              unlock_nxt = job_r.is_second ? 2'd2 : 2'd0;
            end else if (unlock_r == 2'd2) begin
              unlock_nxt = job_r.is_third ? 2'd3 : 2'd0;
            end else begin
              case (job_r.frame[63:62])
                cfps_pkg::CMD_READ: begin
                  base_nxt = off;
                  k_nxt    = 3'd0;
                  samp_nxt = 1'b0;
                  st_nxt   = S_WORD;
                end
                cfps_pkg::CMD_WRITE: begin
                  base_nxt = off;
                  k_nxt    = 3'd0;
                  samp_nxt = 1'b0;
                  st_nxt   = wr_ok ? S_WR : S_WORD;
                end
                cfps_pkg::CMD_TABLE: begin
                  if (job_r.is_count) begin
                    mc_nxt = (job_r.frame[7:0] > {1'b0, TE_CNT}) ? TE_CNT
                                                                 : job_r.frame[CW-1:0];
                  end else begin
                    am_we      = ({1'b0, size} < TE_CNT);
                    rframe_nxt = job_r.frame;
                    rpend_nxt  = 1'b1;
                    if (job_r.frame[31:30] == 2'b11) begin
                      st_nxt = S_TBL2;
                    end
                  end
                end
                default: st_nxt = S_IDLE;
              endcase
            end
          end
          cfps_pkg::KIND_TICK: begin
            rem_nxt = 16'd0;
            tsh_nxt = job_r.time_ms;
            cnt_nxt = 5'd0;
            st_nxt  = S_DIV;
          end
          cfps_pkg::KIND_CONF: begin
            if (job_r.slot < cfps_pkg::RESP_CHANNEL) begin
              busy_nxt[job_r.slot[2:0]] = 1'b0;
            end else if (job_r.slot == cfps_pkg::RESP_CHANNEL) begin
              rbusy_nxt = 1'b0;
            end
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_TBL2: begin
        am_we    = ({1'b0, job_r.frame[29:24]} < TE_CNT);
        am_waddr = job_r.frame[24 +: TIW];
        am_wdata = job_r.frame[23:0];
        st_nxt   = S_IDLE;
      end
      S_WR: begin
        st_we = 1'b1;
        k_nxt = k_r + 3'd1;
        if ({3'd0, k_r} + 6'd1 == size) begin
          k_nxt  = 3'd0;
          st_nxt = S_WORD;
        end
      end
      S_WORD: begin
        k_nxt = k_r + 3'd1;
        if (k_r != 3'd0) begin
          word_nxt = word_fill;
        end
        if (k_r == 3'd4) begin
          if (samp_r) begin
            sm_we   = 1'b1;
            idx_nxt = idx_r + 7'd1;
            st_nxt  = S_SAMPA;
          end else begin
            rframe_nxt = {cfps_pkg::FRAME_HDR, base_r, word_fill};
            rpend_nxt  = 1'b1;
            st_nxt     = S_IDLE;
          end
        end
      end
      S_DIV: begin
        rem_nxt = (trial >= {1'b0, per}) ? 16'(trial - {1'b0, per}) : trial[15:0];
        tsh_nxt = {tsh_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          st_nxt = S_TDEC;
        end
      end
      S_TDEC: begin
        due_nxt   = due_now;
        burst_nxt = burst_now;
        idx_nxt   = '0;
        if (rpend_r && !rbusy_r) begin
          st_nxt = S_RESP;
        end else if (due_now) begin
          st_nxt = S_SAMPA;
        end else if (burst_now) begin
          st_nxt = S_HDRA;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_ok) begin
          out_load             = 1'b1;
          out_data_nxt.channel = cfps_pkg::RESP_CHANNEL;
          out_data_nxt.payload = rframe_r;
          out_data_nxt.last    = !burst_r;
          rpend_nxt            = 1'b0;
          rbusy_nxt            = 1'b1;
          st_nxt = due_r ? S_SAMPA : (burst_r ? S_HDRA : S_IDLE);
        end
      end
      S_SAMPA: begin
        if (idx_r < mc_r) begin
          st_nxt = S_SAMPB;
        end else begin
          si_nxt   = '0;
          busy_nxt = '0;
          st_nxt   = burst_r ? S_HDRA : S_IDLE;
        end
      end
      S_SAMPB: begin
        if (samp_ok) begin
          base_nxt = am_val;
          k_nxt    = 3'd0;
          samp_nxt = 1'b1;
          st_nxt   = S_WORD;
        end else begin
          idx_nxt = idx_r + 7'd1;
          st_nxt  = S_SAMPA;
        end
      end
      S_HDRA: begin
        am_raddr = si_r[TIW-1:0];
        c_nxt    = (diff > {3'd0, cfps_pkg::MAX_BURST}) ? cfps_pkg::MAX_BURST : diff[3:0];
        st_nxt   = S_HDRE;
      end
      S_HDRE: begin
        if (out_ok) begin
          out_load             = 1'b1;
          out_data_nxt.channel = 4'd0;
          out_data_nxt.payload = {cfps_pkg::FRAME_HDR, am_val, 4'd0, c_r, 24'hFFFFFF};
          out_data_nxt.last    = 1'b0;
          busy_nxt[0]          = 1'b1;
          slot_nxt             = 3'd1;
          st_nxt               = S_DATA;
        end
      end
      S_DATA: begin
        st_nxt = S_DATB;
      end
      S_DATB: begin
        hi_nxt = sm_val;
        si_nxt = si_inc;
        c_nxt  = c_r - 4'd1;
        if (c_r >= 4'd2) begin
          sm_raddr = si_inc[TIW-1:0];
          st_nxt   = S_DATC;
        end else begin
          word_nxt = 32'hFFFFFFFF;
          st_nxt   = S_DATE;
        end
      end
      S_DATC: begin
        word_nxt = sm_val;
        si_nxt   = si_inc;
        c_nxt    = c_r - 4'd1;
        st_nxt   = S_DATE;
      end
      S_DATE: begin
        if (out_ok) begin
          out_load             = 1'b1;
          out_data_nxt.channel = {1'b0, slot_r};
          out_data_nxt.payload = {hi_r, word_r};
          out_data_nxt.last    = (c_r == 4'd0);
          busy_nxt[slot_r]     = 1'b1;
          slot_nxt             = slot_r + 3'd1;
          st_nxt               = (c_r == 4'd0) ? S_IDLE : S_DATA;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_INIT;
      clr_r       <= '0;
      unlock_r    <= 2'd0;
      mc_r        <= '0;
      si_r        <= '0;
      busy_r      <= '0;
      rbusy_r     <= 1'b0;
      rpend_r     <= 1'b0;
      rframe_r    <= 64'd0;
      out_valid_r <= 1'b0;
      am_vld_r    <= '0;
      sm_vld_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      unlock_r <= unlock_nxt;
      mc_r     <= mc_nxt;
      si_r     <= si_nxt;
      busy_r   <= busy_nxt;
      rbusy_r  <= rbusy_nxt;
      rpend_r  <= rpend_nxt;
      rframe_r <= rframe_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (am_we) begin
        am_vld_r[am_waddr] <= 1'b1;
      end
      if (sm_we) begin
        sm_vld_r[sm_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    k_r        <= k_nxt;
    base_r     <= base_nxt;
    word_r     <= word_nxt;
    samp_r     <= samp_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    tsh_r      <= tsh_nxt;
    cnt_r      <= cnt_nxt;
    due_r      <= due_nxt;
    burst_r    <= burst_nxt;
    c_r        <= c_nxt;
    slot_r     <= slot_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    st_rd_r <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (am_we) begin
      am_mem[am_waddr] <= am_wdata;
    end
    am_rd_r <= am_mem[am_raddr];
    am_rv_r <= am_vld_r[am_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    sm_rd_r <= sm_mem[sm_raddr];
    sm_rv_r <= sm_vld_r[sm_raddr];
  end

  assign init_done = (st_r != S_INIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mc_r <= TE_CNT)
    else $error("monitored count exceeds table size");

  a_hdr_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_HDRE) |-> (si_r < mc_r))
    else $error("burst header with nothing left to send");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TDEC) |-> (rem_r < per))
    else $error("remainder not reduced below the period");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_INIT) |-> !pop)
    else $error("job taken during the store clearing pass");

endmodule

### design/calibration_frame_protocol_slave_top.sv
// The back end handles one item at a time through a byte-wide store port. A tick first
// reduces its time stamp modulo the sample period, then may send a pending response,
// sample the monitored entries and send burst frames.
// Reset is synchronous and active low; after it the byte store is swept to zero,
// one byte per cycle, and no input transfer is taken until the sweep ends.
// Configuration writes are taken at any time.
module calibration_frame_protocol_slave_top #(
  parameter int TABLE_ENTRIES   = cfps_pkg::DEF_TABLE_ENTRIES,
  parameter int STORE_ADDR_BITS = cfps_pkg::DEF_STORE_ADDR_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cfps_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cfps_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfps_pkg::WINDOW_W-1:0]     cfg_data
);

  // The front classifies each transfer and drops unknown operations and slot
  // codes; the back runs the protocol, the monitor sampling and the bursts.
  cfps_pkg::job_t front_job;
  cfps_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  logic           init_done;

  logic [cfps_pkg::PERIOD_W-1:0] sample_period_r;
  logic [cfps_pkg::WINDOW_W-1:0] window_last_r;

  // Configuration registers accept every transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= cfps_pkg::PERIOD_RESET;
      window_last_r   <= cfps_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfps_pkg::CFG_PERIOD: sample_period_r <= cfg_data[cfps_pkg::PERIOD_W-1:0];
        cfps_pkg::CFG_WINDOW: window_last_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  cfps_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_done (init_done),
    .q_full    (q_full),
    .push      (push),
    .job       (front_job)
  );

  // Two-entry queue lets the front keep taking transfers while the back works.
  cfps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  cfps_back #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .STORE_ADDR_BITS (STORE_ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (head_job),
    .q_empty       (q_empty),
    .pop           (pop),
    .init_done     (init_done),
    .sample_period (sample_period_r),
    .window_last   (window_last_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule
